// ===== rtl/core/ldpr_pkg.sv =====
// Shared types and constants for the dirty page refresh engine.
// No dependencies; imported by ldpr_ctrl, ldpr_dpath and lcd_dirty_page_refresh.
package ldpr_pkg;

  // action codes
  localparam logic [2:0] ACT_WRITE    = 3'd0;
  localparam logic [2:0] ACT_FILL     = 3'd1;
  localparam logic [2:0] ACT_REF_ALL  = 3'd2;
  localparam logic [2:0] ACT_REF_ONE  = 3'd3;
  localparam logic [2:0] ACT_INVAL    = 3'd4;
  localparam logic [2:0] ACT_CONTRAST = 3'd5;
  localparam logic [2:0] ACT_TICK     = 3'd6;

  // byte sequencer phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_EV    = 3'd1;
  localparam logic [2:0] PH_EVVAL = 3'd2;
  localparam logic [2:0] PH_START = 3'd3;
  localparam logic [2:0] PH_PAGE  = 3'd4;
  localparam logic [2:0] PH_CHI   = 3'd5;
  localparam logic [2:0] PH_CLO   = 3'd6;
  localparam logic [2:0] PH_DATA  = 3'd7;

  // panel command bytes
  localparam logic [7:0]  CMD_START_LINE = 8'h40;
  localparam logic [7:0]  CMD_PAGE_BASE  = 8'hB0;
  localparam logic [7:0]  CMD_COL_HI     = 8'h10;
  localparam logic [7:0]  COL_LO_MASK    = 8'h0F;
  localparam logic [7:0]  CMD_CONTRAST   = 8'h81;
  localparam logic [7:0]  CONTRAST_BIAS  = 8'd23;
  localparam logic [31:0] SUM_INVALID    = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] page;
    logic [6:0] column;
    logic [7:0] value;
  } item_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       is_data;
    logic       frame_first;
    logic       frame_last;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic       load_item;
    logic       rd_seq;
    logic       wr_byte;
    logic       fill_start;
    logic       sweep_wr;
    logic       sweep_zero;
    logic       refresh_all;
    logic       refresh_one;
    logic       invalidate;
    logic       contrast;
    logic       emit;
    logic       step_page;
    logic       first;
    logic       last;
    logic [2:0] phase;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] action;
    logic       item_ok;
    logic       page_ok;
    logic       any_diff;
    logic       page_diff;
    logic       last_byte;
    logic       next_valid;
    logic       out_free;
    logic       sweep_done;
  } sts_t;

endpackage

// ===== rtl/core/lcd_dirty_page_refresh.sv =====
// Flow: each request passes the idle and execute states before the next is
// accepted; a byte write adds a write state (read-modify-write of the frame
// store and page sum), a tick that sends a byte adds an emit state that waits
// for a free output register, and a fill adds a sweep over the frame store.
// Reset: a clearing pass zeroes all PAGES*PAGE_BYTES bytes of the frame store
// (1024 at default size), with input stalled; column offset resets to 4.
module lcd_dirty_page_refresh #(
  parameter int PAGES      = 8,
  parameter int PAGE_BYTES = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ldpr_pkg::item_t   in_item_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ldpr_pkg::result_t out_item_o,
  // column offset register write
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [6:0]        cfg_data_i
);
  import ldpr_pkg::*;

  // Controller owns the top state machine and the byte sequencer phase;
  // the datapath holds the frame store (single-port write, registered read),
  // per-page running sums and last-sent sums, and the output register.
  cmd_t cmd;
  sts_t sts;

  // Only one request in flight: the controller stalls input outside idle.
  ldpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Output register decouples ticks from the panel-side stall; a tick waits
  // in the controller until the register is free.
  ldpr_dpath #(
    .PAGES      (PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== rtl/core/ldpr_ctrl.sv =====
// Control state machine and byte sequencer of the dirty page refresh engine.
// Depends on ldpr_pkg; drives ldpr_dpath through cmd_t and reads sts_t.
module ldpr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ldpr_pkg::sts_t sts_i,
  output ldpr_pkg::cmd_t cmd_o
);
  import ldpr_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_FILL  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [2:0] phase_q, phase_d;
  logic       single_q, single_d;
  logic       open_q, open_d;
  cmd_t       cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      phase_q  <= PH_IDLE;
      single_q <= 1'b0;
      open_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      single_q <= single_d;
      open_q   <= open_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    single_d  = single_q;
    open_d    = open_q;
    cmd       = '0;
    cmd.phase = phase_q;
    case (state_q)
      ST_CLEAR: begin
        cmd.sweep_wr   = 1'b1;
        cmd.sweep_zero = 1'b1;
        if (sts_i.sweep_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load_item = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        if (sts_i.action == ACT_TICK) begin
          cmd.rd_seq = 1'b1;
          if (phase_q != PH_IDLE) state_d = ST_EMIT;
        end else if (phase_q == PH_IDLE) begin
          case (sts_i.action)
            ACT_WRITE: begin
              if (sts_i.item_ok) state_d = ST_WRITE;
            end
            ACT_FILL: begin
              cmd.fill_start = 1'b1;
              state_d        = ST_FILL;
            end
            ACT_REF_ALL: begin
              cmd.refresh_all = 1'b1;
              if (sts_i.any_diff) begin
                single_d = 1'b0;
                open_d   = 1'b0;
                phase_d  = PH_PAGE;
              end
            end
            ACT_REF_ONE: begin
              if (sts_i.page_ok && sts_i.page_diff) begin
                cmd.refresh_one = 1'b1;
                single_d        = 1'b1;
                open_d          = 1'b0;
                phase_d         = PH_START;
              end
            end
            ACT_INVAL: cmd.invalidate = 1'b1;
            ACT_CONTRAST: begin
              cmd.contrast = 1'b1;
              open_d       = 1'b0;
              phase_d      = PH_EV;
            end
            default: ;
          endcase
        end
      end
      ST_WRITE: begin
        cmd.wr_byte = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_FILL: begin
        cmd.sweep_wr = 1'b1;
        if (sts_i.sweep_done) state_d = ST_IDLE;
      end
      ST_EMIT: begin
        cmd.rd_seq = 1'b1;
        if (sts_i.out_free) begin
          cmd.emit  = 1'b1;
          cmd.first = !open_q;
          case (phase_q)
            PH_EV:    phase_d = PH_EVVAL;
            PH_EVVAL: begin
              phase_d  = PH_IDLE;
              cmd.last = 1'b1;
            end
            PH_START: phase_d = PH_PAGE;
            PH_PAGE:  phase_d = PH_CHI;
            PH_CHI:   phase_d = PH_CLO;
            PH_CLO:   phase_d = PH_DATA;
            PH_DATA: begin
              if (sts_i.last_byte) begin
                if (single_q || !sts_i.next_valid) begin
                  phase_d  = PH_IDLE;
                  cmd.last = 1'b1;
                end else begin
                  phase_d       = PH_PAGE;
                  cmd.step_page = 1'b1;
                end
              end
            end
            default: phase_d = PH_IDLE;
          endcase
          open_d  = (phase_d != PH_IDLE);
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign cmd_o      = cmd;
  assign in_stall_o = (state_q != ST_IDLE);

`ifndef SYNTHESIS
  a_sweep_idle_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR || state_q == ST_FILL) |-> phase_q == PH_IDLE)
    else $error("sequencer active during memory sweep");
  a_open_has_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> phase_q != PH_IDLE)
    else $error("frame open with idle sequencer");
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> phase_q != PH_IDLE)
    else $error("emit state with idle sequencer");
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && cmd.last) |=> (phase_q == PH_IDLE && !open_q))
    else $error("frame not closed after last byte");
`endif

endmodule

// ===== rtl/core/ldpr_dpath.sv =====
// Datapath of the dirty page refresh engine: frame store, page sums, pointers,
// column offset register and output register. Depends on ldpr_pkg.
module ldpr_dpath #(
  parameter int PAGES      = 8,
  parameter int PAGE_BYTES = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ldpr_pkg::item_t   in_item_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [6:0]        cfg_data_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output ldpr_pkg::result_t out_item_o,
  input  ldpr_pkg::cmd_t    cmd_i,
  output ldpr_pkg::sts_t    sts_o
);
  import ldpr_pkg::*;

  localparam int DEPTH       = PAGES * PAGE_BYTES;
  localparam int AW          = $clog2(DEPTH);
  localparam int PW          = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int BW          = $clog2(PAGE_BYTES);
  localparam int WHOLE_BYTES = (PAGE_BYTES / 4) * 4;
  localparam int WORDS       = PAGE_BYTES / 4;
  localparam int TAIL        = PAGE_BYTES % 4;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_q;
  item_t         item_q;
  logic [31:0]   cur_q  [PAGES];
  logic [31:0]   cur_d  [PAGES];
  logic [31:0]   sent_q [PAGES];
  logic [31:0]   sent_d [PAGES];
  logic [PAGES-1:0] flags_q, flags_d, diff;
  logic [PW-1:0] pp_q, pp_d, page_idx, first_idx, next_idx;
  logic [BW-1:0] bc_q, bc_d;
  logic [AW-1:0] sweep_q, sweep_d;
  logic [7:0]    fill_q;
  logic [6:0]    co_q;
  logic [7:0]    contrast_q;
  logic          out_valid_q;
  result_t       out_q, res;
  logic [10:0]   item_addr, seq_addr;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0]    wr_data;
  logic          wr_en;
  logic          next_valid;
  logic [3:0]    page_ext;
  logic signed [8:0] delta;
  logic [31:0]   delta_ext, delta_sh;
  logic [4:0]    sh;
  logic [31:0]   fill_sum;

  // address generation
  assign page_ext  = 4'(item_q.page);
  assign page_idx  = page_ext[PW-1:0];
  assign item_addr = 11'(item_q.page) * 11'(PAGE_BYTES) + 11'(item_q.column);
  assign seq_addr  = 11'(pp_q) * 11'(PAGE_BYTES) + 11'(bc_q);
  assign rd_addr   = cmd_i.rd_seq ? seq_addr[AW-1:0] : item_addr[AW-1:0];
  assign wr_addr   = cmd_i.sweep_wr ? sweep_q : item_addr[AW-1:0];
  assign wr_data   = cmd_i.sweep_zero ? 8'h00 : (cmd_i.sweep_wr ? fill_q : item_q.value);
  assign wr_en     = cmd_i.sweep_wr || cmd_i.wr_byte;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr];
  end

  // write byte: sum moves by (new - old) at the byte's lane
  assign sh        = ({1'b0, item_q.column} < 8'(WHOLE_BYTES)) ?
                     {item_q.column[1:0], 3'b000} : 5'd0;
  assign delta     = $signed({1'b0, item_q.value}) - $signed({1'b0, rd_q});
  assign delta_ext = {{23{delta[8]}}, delta};
  assign delta_sh  = delta_ext << sh;

  assign fill_sum  = 32'(WORDS) * {4{item_q.value}} + 32'(TAIL) * {24'd0, item_q.value};

  // page scan
  always_comb begin
    first_idx  = '0;
    next_idx   = '0;
    next_valid = 1'b0;
    for (int p = 0; p < PAGES; p++) begin
      diff[p] = (cur_q[p] != sent_q[p]);
    end
    for (int p = PAGES - 1; p >= 0; p--) begin
      if (diff[p]) first_idx = PW'(p);
      if (flags_q[p] && (p > int'(pp_q))) begin
        next_idx   = PW'(p);
        next_valid = 1'b1;
      end
    end
  end

  always_comb begin
    for (int p = 0; p < PAGES; p++) begin
      cur_d[p]  = cur_q[p];
      sent_d[p] = sent_q[p];
      if (cmd_i.fill_start) begin
        cur_d[p]  = fill_sum;
        sent_d[p] = SUM_INVALID;
      end
      if (cmd_i.invalidate) sent_d[p] = SUM_INVALID;
      if (cmd_i.refresh_all && diff[p]) sent_d[p] = cur_q[p];
    end
    if (cmd_i.wr_byte) cur_d[page_idx] = cur_q[page_idx] + delta_sh;
    if (cmd_i.refresh_one) sent_d[page_idx] = cur_q[page_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PAGES; p++) begin
        cur_q[p]  <= '0;
        sent_q[p] <= SUM_INVALID;
      end
    end else begin
      for (int p = 0; p < PAGES; p++) begin
        cur_q[p]  <= cur_d[p];
        sent_q[p] <= sent_d[p];
      end
    end
  end

  // pointers
  always_comb begin
    flags_d = flags_q;
    pp_d    = pp_q;
    bc_d    = bc_q;
    sweep_d = sweep_q;
    if (cmd_i.fill_start) sweep_d = '0;
    if (cmd_i.sweep_wr) sweep_d = sweep_q + 1'b1;
    if (cmd_i.refresh_all) begin
      flags_d = diff;
      if (|diff) begin
        pp_d = first_idx;
        bc_d = '0;
      end
    end
    if (cmd_i.refresh_one) begin
      pp_d = page_idx;
      bc_d = '0;
    end
    if (cmd_i.emit) begin
      if (cmd_i.phase == PH_CLO) bc_d = '0;
      if (cmd_i.phase == PH_DATA) begin
        if (bc_q == BW'(PAGE_BYTES - 1)) bc_d = '0;
        else bc_d = bc_q + 1'b1;
        if (cmd_i.step_page) pp_d = next_idx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      pp_q        <= '0;
      bc_q        <= '0;
      sweep_q     <= '0;
      co_q        <= 7'd4;
      out_valid_q <= 1'b0;
    end else begin
      flags_q <= flags_d;
      pp_q    <= pp_d;
      bc_q    <= bc_d;
      sweep_q <= sweep_d;
      if (cfg_valid_i) co_q <= cfg_data_i;
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= in_item_i;
    if (cmd_i.fill_start) fill_q <= item_q.value;
    if (cmd_i.contrast) contrast_q <= item_q.value + CONTRAST_BIAS;
    if (cmd_i.emit) out_q <= res;
  end

  // outgoing byte
  always_comb begin
    res             = '0;
    res.frame_first = cmd_i.first;
    res.frame_last  = cmd_i.last;
    case (cmd_i.phase)
      PH_EV:    res.spi_byte = CMD_CONTRAST;
      PH_EVVAL: res.spi_byte = contrast_q;
      PH_START: res.spi_byte = CMD_START_LINE;
      PH_PAGE:  res.spi_byte = CMD_PAGE_BASE + 8'(pp_q);
      PH_CHI:   res.spi_byte = CMD_COL_HI | {5'd0, co_q[6:4]};
      PH_CLO:   res.spi_byte = {1'b0, co_q} & COL_LO_MASK;
      PH_DATA: begin
        res.spi_byte = rd_q;
        res.is_data  = 1'b1;
      end
      default:  res.spi_byte = '0;
    endcase
  end

  assign sts_o.action     = item_q.action;
  assign sts_o.page_ok    = {1'b0, page_ext} < 5'(PAGES);
  assign sts_o.item_ok    = sts_o.page_ok && ({1'b0, item_q.column} < 8'(PAGE_BYTES));
  assign sts_o.any_diff   = |diff;
  assign sts_o.page_diff  = diff[page_idx];
  assign sts_o.last_byte  = (bc_q == BW'(PAGE_BYTES - 1));
  assign sts_o.next_valid = next_valid;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign sts_o.sweep_done = (sweep_q == AW'(DEPTH - 1));

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for lcd_dirty_page_refresh: a directed table of requests, then random
// request streams checked against a behavioural model of the page sums and byte sequencer.
// Depends on ldpr_pkg and the RTL only.
module testbench;
  import ldpr_pkg::*;

  localparam int PAGES      = 8;
  localparam int PAGE_BYTES = 128;
  // bytes that fall in whole little-endian words; any tail is summed as plain bytes
  localparam int WORD_BYTES = (PAGE_BYTES / 4) * 4;
  localparam logic [2:0] ACT_UNUSED = 3'd7;

  // a fill walks the whole store; pause at least that long before a register write
  localparam int SETTLE_CYCLES  = PAGES * PAGE_BYTES + 64;
  localparam int PHASES         = 5;
  localparam int PHASE_REQUESTS = 350;
  localparam int SQUEEZE_AFTER  = 200;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int CYCLE_LIMIT    = 500000;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  item_t      in_item_i;
  logic       out_valid_o;
  logic       out_stall_i;
  result_t    out_item_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [6:0] cfg_data_i;

  lcd_dirty_page_refresh #(
    .PAGES      (PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Model of the block: frame store, page sums and the SPI byte sequencer.
  // ---------------------------------------------------------------------------
  logic [7:0]       pixels    [PAGES * PAGE_BYTES];
  logic [31:0]      page_sum  [PAGES];   // running sum of the page contents
  logic [31:0]      panel_sum [PAGES];   // sum the panel was last sent
  logic [PAGES-1:0] sweep_mask;          // pages picked by the last refresh-changed
  logic [2:0]       seq_phase;
  logic [2:0]       page_ptr;
  int               col_idx;
  logic [7:0]       contrast_cmd;
  logic [6:0]       col_offset;
  bit               one_page;
  bit               cs_active;

  result_t spi_expected [$];             // SPI bytes owed by the block, oldest first
  int      failures = 0;
  bit      sender_calm = 1'b0;
  bit      sink_calm = 1'b0;

  function automatic int next_swept(int after);
    for (int p = after + 1; p < PAGES; p++)
      if (sweep_mask[p]) return p;
    return -1;
  endfunction

  // Applies one accepted request; returns 1 with the byte it releases, if any.
  // acted is low for ticks on an idle sequencer, for requests a busy sequencer drops and for code 7.
  function automatic bit predict_spi(input item_t req, output result_t res, output bit acted);
    int          nxt;
    int          base;
    int          sh;
    logic [31:0] fill_sum;
    res   = '0;
    acted = 1'b0;
    if (req.action == ACT_TICK) begin
      if (seq_phase == PH_IDLE) return 1'b0;
      acted = 1'b1;
      res.frame_first = !cs_active;
      cs_active = 1'b1;
      case (seq_phase)
        PH_EV: begin
          res.spi_byte = CMD_CONTRAST;
          seq_phase = PH_EVVAL;
        end
        PH_EVVAL: begin
          res.spi_byte = contrast_cmd;
          res.frame_last = 1'b1;
          seq_phase = PH_IDLE;
        end
        PH_START: begin
          res.spi_byte = CMD_START_LINE;
          seq_phase = PH_PAGE;
        end
        PH_PAGE: begin
          res.spi_byte = CMD_PAGE_BASE + 8'(page_ptr);
          seq_phase = PH_CHI;
        end
        // column offset is read here, so a write lands at the next column command
        PH_CHI: begin
          res.spi_byte = CMD_COL_HI | 8'(col_offset[6:4]);
          seq_phase = PH_CLO;
        end
        PH_CLO: begin
          res.spi_byte = COL_LO_MASK & 8'(col_offset[3:0]);
          col_idx = 0;
          seq_phase = PH_DATA;
        end
        default: begin
          res.spi_byte = pixels[int'(page_ptr) * PAGE_BYTES + col_idx];
          res.is_data = 1'b1;
          if (col_idx + 1 < PAGE_BYTES) begin
            col_idx++;
          end else begin
            col_idx = 0;
            nxt = one_page ? -1 : next_swept(int'(page_ptr));
            if (nxt < 0) begin
              res.frame_last = 1'b1;
              seq_phase = PH_IDLE;
            end else begin
              page_ptr = 3'(nxt);
              seq_phase = PH_PAGE;
            end
          end
        end
      endcase
      if (seq_phase == PH_IDLE) cs_active = 1'b0;
      return 1'b1;
    end

    // busy sequencer drops everything but ticks; code 7 is never decoded
    if (seq_phase != PH_IDLE || req.action == ACT_UNUSED) return 1'b0;
    acted = 1'b1;
    case (req.action)
      ACT_WRITE: begin
        if (int'(req.page) < PAGES && int'(req.column) < PAGE_BYTES) begin
          base = int'(req.page) * PAGE_BYTES + int'(req.column);
          sh = (int'(req.column) < WORD_BYTES) ? 8 * int'(req.column[1:0]) : 0;
          page_sum[req.page] = page_sum[req.page] - (32'(pixels[base]) << sh)
                               + (32'(req.value) << sh);
          pixels[base] = req.value;
        end
      end
      ACT_FILL: begin
        fill_sum = 32'(PAGE_BYTES / 4) * (32'(req.value) * 32'h0101_0101)
                   + 32'(PAGE_BYTES % 4) * 32'(req.value);
        foreach (pixels[i]) pixels[i] = req.value;
        for (int p = 0; p < PAGES; p++) begin
          page_sum[p]  = fill_sum;
          panel_sum[p] = SUM_INVALID;
        end
      end
      ACT_REF_ALL: begin
        sweep_mask = '0;
        for (int p = 0; p < PAGES; p++) begin
          if (page_sum[p] != panel_sum[p]) begin
            sweep_mask[p] = 1'b1;
            panel_sum[p]  = page_sum[p];
          end
        end
        nxt = next_swept(-1);
        if (nxt >= 0) begin
          page_ptr  = 3'(nxt);
          col_idx   = 0;
          one_page  = 1'b0;
          cs_active = 1'b0;
          seq_phase = PH_PAGE;
        end
      end
      ACT_REF_ONE: begin
        if (int'(req.page) < PAGES && page_sum[req.page] != panel_sum[req.page]) begin
          panel_sum[req.page] = page_sum[req.page];
          page_ptr  = req.page;
          col_idx   = 0;
          one_page  = 1'b1;
          cs_active = 1'b0;
          seq_phase = PH_START;
        end
      end
      ACT_INVAL: begin
        for (int p = 0; p < PAGES; p++) panel_sum[p] = SUM_INVALID;
      end
      ACT_CONTRAST: begin
        contrast_cmd = CONTRAST_BIAS + req.value;
        cs_active = 1'b0;
        seq_phase = PH_EV;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Next random request. A running frame mostly gets ticks, with some noise the block must
  // drop; otherwise writes cluster on two focus pages so that refreshes stay short.
  function automatic item_t pick_request(input logic [2:0] focus_a, input logic [2:0] focus_b);
    item_t      r;
    int         pick;
    int         start;
    int         pg;
    int         stale_count;
    logic [2:0] target;
    r.action = ACT_TICK;
    r.page   = 3'($urandom_range(0, 7));
    r.column = 7'($urandom_range(0, 127));
    r.value  = 8'($urandom_range(0, 255));
    if (seq_phase != PH_IDLE) begin
      if ($urandom_range(0, 9) == 0) r.action = 3'($urandom_range(0, 7));
      return r;
    end

    // stale pages: count them, and aim refreshes at one, now and then at any page
    stale_count = 0;
    start  = $urandom_range(0, PAGES - 1);
    target = 3'(start);
    for (int k = PAGES - 1; k >= 0; k--) begin
      pg = (start + k) % PAGES;
      if (page_sum[pg] != panel_sum[pg]) begin
        stale_count++;
        target = 3'(pg);
      end
    end
    if ($urandom_range(0, 3) == 0) target = r.page;

    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      r.action = ACT_WRITE;
      if ($urandom_range(0, 4) != 0) r.page = $urandom_range(0, 1) ? focus_a : focus_b;
    end else if (pick < 60) begin
      r.action = ACT_REF_ONE;
      r.page = target;
    end else if (pick < 67) begin
      // a sweep over every page costs a thousand ticks; keep sweeps to a few pages
      if (stale_count <= 3) begin
        r.action = ACT_REF_ALL;
      end else begin
        r.action = ACT_REF_ONE;
        r.page = target;
      end
    end else if (pick < 74) begin
      r.action = ACT_CONTRAST;
    end else if (pick < 84) begin
      r.action = ACT_TICK;
    end else if (pick < 88) begin
      r.action = ACT_INVAL;
    end else if (pick < 90) begin
      r.action = ACT_FILL;
    end else if (pick < 93) begin
      r.action = ACT_UNUSED;
    end else begin
      r.action = ACT_WRITE;
      r.value = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Called at a rising edge; returns at the edge that accepts.
  // ---------------------------------------------------------------------------
  task automatic offer(input item_t req, input bit typed, input result_t want,
                       output bit acted);
    int      gap;
    bit      has_res;
    result_t res;
    if ($urandom_range(0, 49) == 0) sender_calm = !sender_calm;
    gap = sender_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    has_res = predict_spi(req, res, acted);
    // rows with a hand-typed byte take that instead of the model's
    if (typed) begin
      res = want;
      has_res = 1'b1;
    end
    if (has_res) spi_expected.push_back(res);
  endtask

  // Drop valid, wait for every owed byte, then let a possible fill finish.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (spi_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Directed requests. Bytes typed in are the ones plain from the spec: contrast frame,
  // start of a single page frame at the reset column offset of 4.
  typedef struct packed {
    item_t   req;
    logic    typed;
    result_t want;
  } table_row_t;

  localparam int DIRECTED_ROWS = 17;
  table_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{ACT_TICK,     3'd0, 7'd0,   8'h00}, 1'b0, '0},  // idle tick: nothing sent
    '{'{ACT_UNUSED,   3'd7, 7'd127, 8'hFF}, 1'b0, '0},  // unused code dropped
    '{'{ACT_CONTRAST, 3'd0, 7'd0,   8'hFF}, 1'b0, '0},
    '{'{ACT_WRITE,    3'd7, 7'd127, 8'hFF}, 1'b0, '0},  // dropped, contrast frame open
    '{'{ACT_TICK,     3'd0, 7'd0,   8'h00}, 1'b1, '{CMD_CONTRAST, 1'b0, 1'b1, 1'b0}},
    '{'{ACT_TICK,     3'd0, 7'd0,   8'h00}, 1'b1, '{8'h16, 1'b0, 1'b0, 1'b1}},  // 23+255 wraps
    '{'{ACT_TICK,     3'd0, 7'd0,   8'h00}, 1'b0, '0},
    '{'{ACT_WRITE,    3'd0, 7'd0,   8'hFF}, 1'b0, '0},
    '{'{ACT_WRITE,    3'd7, 7'd127, 8'h80}, 1'b0, '0},
    '{'{ACT_INVAL,    3'd0, 7'd0,   8'h00}, 1'b0, '0},
    '{'{ACT_REF_ONE,  3'd7, 7'd0,   8'h00}, 1'b0, '0},
    '{'{ACT_CONTRAST, 3'd0, 7'd0,   8'h00}, 1'b0, '0},  // dropped, refresh running
    '{'{ACT_TICK,     3'd0, 7'd0,   8'h00}, 1'b1, '{CMD_START_LINE, 1'b0, 1'b1, 1'b0}},
    '{'{ACT_TICK,     3'd0, 7'd0,   8'h00}, 1'b1, '{CMD_PAGE_BASE + 8'd7, 1'b0, 1'b0, 1'b0}},
    '{'{ACT_TICK,     3'd0, 7'd0,   8'h00}, 1'b1, '{CMD_COL_HI, 1'b0, 1'b0, 1'b0}},
    '{'{ACT_TICK,     3'd0, 7'd0,   8'h00}, 1'b1, '{8'h04, 1'b0, 1'b0, 1'b0}},
    '{'{ACT_TICK,     3'd0, 7'd0,   8'h00}, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}}
  };

  initial begin : stimulus
    item_t      req;
    bit         acted;
    int         counted;
    logic [2:0] focus_a;
    logic [2:0] focus_b;
    logic [6:0] offset;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;

    foreach (pixels[i]) pixels[i] = 8'h00;
    for (int p = 0; p < PAGES; p++) begin
      page_sum[p]  = '0;
      panel_sum[p] = SUM_INVALID;
    end
    sweep_mask   = '0;
    seq_phase    = PH_IDLE;
    page_ptr     = '0;
    col_idx      = 0;
    contrast_cmd = '0;
    col_offset   = 7'd4;
    one_page     = 1'b0;
    cs_active    = 1'b0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the clearing pass after reset holds stall high; offer simply waits it out
    foreach (directed_rows[i])
      offer(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want, acted);

    // each phase: drain, new column offset (extremes first), then a random stream
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      offset = (ph == 0) ? 7'd0 : (ph == 1) ? 7'h7F : 7'($urandom_range(0, 127));
      cfg_valid_i <= 1'b1;
      cfg_data_i  <= offset;
      do @(posedge clk_i); while (!cfg_ready_o);
      cfg_valid_i <= 1'b0;
      col_offset = offset;

      focus_a = 3'($urandom_range(0, 7));
      focus_b = 3'($urandom_range(0, 7));
      counted = 0;
      while (counted < PHASE_REQUESTS) begin
        req = pick_request(focus_a, focus_b);
        offer(req, 1'b0, '0, acted);
        if (acted) counted++;
      end
    end

    settle();
    if (failures == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls, one long hold-off mid-frame to back the block up.
  // ---------------------------------------------------------------------------
  initial begin : spi_sink
    int      hold;
    int      got_count;
    bit      squeezed;
    bit      mid_data;
    result_t want;
    result_t got;
    got_count = 0;
    squeezed  = 1'b0;
    mid_data  = 1'b0;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 49) == 0) sink_calm = !sink_calm;
      hold = sink_calm ? 0 : $urandom_range(0, 12);
      if (!squeezed && got_count >= SQUEEZE_AFTER && mid_data) begin
        hold = SQUEEZE_CYCLES;
        squeezed = 1'b1;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got = out_item_o;
      got_count++;
      mid_data = got.is_data && !got.frame_last;

      if (spi_expected.size() == 0) begin
        failures++;
        $error("unexpected result: spi_byte %h is_data %b", got.spi_byte, got.is_data);
      end else begin
        want = spi_expected.pop_front();
        if (got.spi_byte !== want.spi_byte) begin
          failures++;
          $error("spi_byte: expected %h, got %h", want.spi_byte, got.spi_byte);
        end
        if (got.is_data !== want.is_data) begin
          failures++;
          $error("is_data: expected %b, got %b", want.is_data, got.is_data);
        end
        if (got.frame_first !== want.frame_first) begin
          failures++;
          $error("frame_first: expected %b, got %b", want.frame_first, got.frame_first);
        end
        if (got.frame_last !== want.frame_last) begin
          failures++;
          $error("frame_last: expected %b, got %b", want.frame_last, got.frame_last);
        end
      end
    end
  end

  // hang guard
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule
